/* rtl/stepper_phase_sequencer_assert.svh */
// Assertion macros shared by the stepper sequencer files.
`ifndef STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define STPS_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define STPS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/stps_pkg.sv */
`timescale 1ns / 1ps

package stps_pkg;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_RUN      = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_MODE     = 3'd3,
      CMD_LOAD_POS = 3'd4
   } command_type;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_DOUBLE = 2'd1;
   localparam logic [1:0] MODE_HALF   = 2'd2;

   typedef struct packed {
      logic [2:0]          command;
      logic signed [31:0]  step_count;
      logic                endless;
      logic [31:0]         step_period;
      logic [1:0]          step_mode;
      logic signed [15:0]  position_value;
   } item_type;

   typedef struct packed {
      logic [3:0]          coils;
      logic                running;
      logic                finished;
      logic                accepted;
      logic signed [15:0]  position;
      logic signed [31:0]  step_total;
      logic [2:0]          phase_index;
   } result_type;

   // Coil pattern for a table mode and phase index.
   function automatic logic [3:0] phase_coils(input logic [1:0] mode, input logic [2:0] idx);
      logic [3:0] c;
      c = 4'h0;
      case (mode)
         MODE_SINGLE: begin
            case (idx[1:0])
               2'd0:    c = 4'h1;
               2'd1:    c = 4'h2;
               2'd2:    c = 4'h4;
               default: c = 4'h8;
            endcase
         end
         MODE_DOUBLE: begin
            case (idx[1:0])
               2'd0:    c = 4'h3;
               2'd1:    c = 4'h6;
               2'd2:    c = 4'hC;
               default: c = 4'h9;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    c = 4'h1;
               3'd1:    c = 4'h3;
               3'd2:    c = 4'h2;
               3'd3:    c = 4'h6;
               3'd4:    c = 4'h4;
               3'd5:    c = 4'hC;
               3'd6:    c = 4'h8;
               default: c = 4'h9;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

/* rtl/stps_if.sv */
`timescale 1ns / 1ps

interface stps_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          command;
   logic signed [31:0]  step_count;
   logic                endless;
   logic [31:0]         step_period;
   logic [1:0]          step_mode;
   logic signed [15:0]  position_value;

   modport source (
      output valid, command, step_count, endless, step_period, step_mode, position_value,
      input  ready
   );
   modport sink (
      input  valid, command, step_count, endless, step_period, step_mode, position_value,
      output ready
   );
endinterface

interface stps_rsp_if;
   logic                valid;
   logic                ready;
   logic [3:0]          coils;
   logic                running;
   logic                finished;
   logic                accepted;
   logic signed [15:0]  position;
   logic signed [31:0]  step_total;
   logic [2:0]          phase_index;

   modport source (
      output valid, coils, running, finished, accepted, position, step_total, phase_index,
      input  ready
   );
   modport sink (
      input  valid, coils, running, finished, accepted, position, step_total, phase_index,
      output ready
   );
endinterface

/* rtl/stepper_phase_sequencer.sv */
`timescale 1ns / 1ps
`include "stepper_phase_sequencer_assert.svh"
// Requests are registered in item_ff, one per cycle while the result queue has
// space. All sequencing state updates in one pass; each result is registered in
// the two-entry queue, which keeps requests flowing while a response waits.
// Reset (synchronous, active high): motor stopped, coils off, eight-step mode,
// step period one, position and step total zero, no response pending.

module stepper_phase_sequencer #(
   parameter int PERIOD_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   stps_req_if.sink    req_ch,
   stps_rsp_if.source  rsp_ch
);

   logic                  in_valid_ff;
   stps_pkg::item_type    item_ff;
   stps_pkg::result_type  step_result;
   stps_pkg::result_type  head_ff;
   stps_pkg::result_type  tail_ff;
   logic                  head_valid_ff;
   logic                  tail_valid_ff;
   logic                  pop;
   logic                  space;
   logic                  advance;
   logic                  req_take;

   assign pop      = head_valid_ff && rsp_ch.ready;
   assign space    = !tail_valid_ff || pop;
   assign advance  = in_valid_ff && space;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   stps_engine #(
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         item_ff.command        <= req_ch.command;
         item_ff.step_count     <= req_ch.step_count;
         item_ff.endless        <= req_ch.endless;
         item_ff.step_period    <= req_ch.step_period;
         item_ff.step_mode      <= req_ch.step_mode;
         item_ff.position_value <= req_ch.position_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         case ({advance, pop})
            2'b10: begin
               if (!head_valid_ff) begin
                  head_valid_ff <= 1'b1;
               end else begin
                  tail_valid_ff <= 1'b1;
               end
            end
            2'b01: begin
               head_valid_ff <= tail_valid_ff;
               tail_valid_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
      // payload moves without reset
      case ({advance, pop})
         2'b10: begin
            if (!head_valid_ff) begin
               head_ff <= step_result;
            end else begin
               tail_ff <= step_result;
            end
         end
         2'b01: begin
            head_ff <= tail_ff;
         end
         2'b11: begin
            if (tail_valid_ff) begin
               head_ff <= tail_ff;
               tail_ff <= step_result;
            end else begin
               head_ff <= step_result;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.valid       = head_valid_ff;
   assign rsp_ch.coils       = head_ff.coils;
   assign rsp_ch.running     = head_ff.running;
   assign rsp_ch.finished    = head_ff.finished;
   assign rsp_ch.accepted    = head_ff.accepted;
   assign rsp_ch.position    = head_ff.position;
   assign rsp_ch.step_total  = head_ff.step_total;
   assign rsp_ch.phase_index = head_ff.phase_index;

   `STPS_ASSERT_IMPLIES(a_queue_order, clock, reset, tail_valid_ff, head_valid_ff, "response tail filled while head empty")
   `STPS_ASSERT_NEXT(a_hold_blocked_request, clock, reset, in_valid_ff && !space, in_valid_ff, "blocked request dropped")

endmodule

/* rtl/stps_engine.sv */
`timescale 1ns / 1ps
`include "stepper_phase_sequencer_assert.svh"

module stps_engine #(
   parameter int PERIOD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  stps_pkg::item_type    item,
   output stps_pkg::result_type  result
);

   logic                     running_ff, running_in;
   logic                     reverse_ff, reverse_in;
   logic [2:0]               phase_ff, phase_in;
   logic [31:0]              steps_left_ff, steps_left_in;
   logic                     no_limit_ff, no_limit_in;
   logic [PERIOD_WIDTH-1:0]  reload_ff, reload_in;
   logic [PERIOD_WIDTH-1:0]  countdown_ff, countdown_in;
   logic [1:0]               mode_ff, mode_in;
   logic [15:0]              position_ff, position_in;
   logic [31:0]              total_ff, total_in;
   logic [3:0]               coils_ff, coils_in;
   logic                     finished;
   logic                     accepted;

   always_comb begin
      logic                     half_mode;
      logic                     new_half;
      logic [2:0]               idx;
      logic [31:0]              left_dec;
      logic [PERIOD_WIDTH-1:0]  period_in;
      logic                     neg;

      running_in    = running_ff;
      reverse_in    = reverse_ff;
      phase_in      = phase_ff;
      steps_left_in = steps_left_ff;
      no_limit_in   = no_limit_ff;
      reload_in     = reload_ff;
      countdown_in  = countdown_ff;
      mode_in       = mode_ff;
      position_in   = position_ff;
      total_in      = total_ff;
      coils_in      = coils_ff;
      finished      = 1'b0;
      accepted      = 1'b1;

      half_mode = (mode_ff == stps_pkg::MODE_HALF);
      new_half  = (item.step_mode == stps_pkg::MODE_HALF);
      idx       = half_mode ? phase_ff : {1'b0, phase_ff[1:0]};
      left_dec  = (steps_left_ff != 32'd0) ? steps_left_ff - 32'd1 : steps_left_ff;
      period_in = item.step_period[PERIOD_WIDTH-1:0];
      neg       = item.step_count[31];

      case (stps_pkg::command_type'(item.command))
         stps_pkg::CMD_TICK: begin
            if (running_ff) begin
               if (countdown_ff > PERIOD_WIDTH'(1)) begin
                  countdown_in = countdown_ff - PERIOD_WIDTH'(1);
               end else begin
                  countdown_in = reload_ff;
                  coils_in     = stps_pkg::phase_coils(mode_ff, idx);
                  total_in     = reverse_ff ? total_ff - 32'd1 : total_ff + 32'd1;
                  if (half_mode) begin
                     position_in = reverse_ff ? position_ff - 16'd1 : position_ff + 16'd1;
                  end else begin
                     position_in = reverse_ff ? position_ff - 16'd2 : position_ff + 16'd2;
                  end
                  if (!no_limit_ff && left_dec == 32'd0) begin
                     // last step of a counted run: release the coils
                     running_in    = 1'b0;
                     reverse_in    = 1'b0;
                     phase_in      = 3'd0;
                     steps_left_in = 32'd0;
                     coils_in      = 4'h0;
                     finished      = 1'b1;
                  end else begin
                     if (!no_limit_ff) begin
                        steps_left_in = left_dec;
                     end
                     if (!reverse_ff) begin
                        phase_in = ((half_mode && idx == 3'd7) || (!half_mode && idx == 3'd3))
                                   ? 3'd0 : idx + 3'd1;
                     end else begin
                        phase_in = (idx == 3'd0) ? (half_mode ? 3'd7 : 3'd3) : idx - 3'd1;
                     end
                  end
               end
            end
         end
         stps_pkg::CMD_RUN: begin
            if (running_ff) begin
               accepted = 1'b0;
            end else if (item.step_count == 32'sd0) begin
               running_in    = 1'b0;
               reverse_in    = 1'b0;
               phase_in      = 3'd0;
               steps_left_in = 32'd0;
               coils_in      = 4'h0;
               finished      = 1'b1;
            end else begin
               running_in    = 1'b1;
               reverse_in    = neg;
               steps_left_in = neg ? 32'(-item.step_count) : 32'(item.step_count);
               no_limit_in   = item.endless;
               reload_in     = (period_in == '0) ? PERIOD_WIDTH'(1) : period_in;
               countdown_in  = (period_in == '0) ? PERIOD_WIDTH'(1) : period_in;
            end
         end
         stps_pkg::CMD_STOP: begin
            running_in    = 1'b0;
            reverse_in    = 1'b0;
            phase_in      = 3'd0;
            steps_left_in = 32'd0;
            coils_in      = 4'h0;
            finished      = 1'b1;
         end
         stps_pkg::CMD_MODE: begin
            if (item.step_mode inside {stps_pkg::MODE_SINGLE, stps_pkg::MODE_DOUBLE,
                                       stps_pkg::MODE_HALF}) begin
               // keep the rotor place when the table length changes
               if (new_half && !half_mode) begin
                  phase_in = {phase_ff[1:0], 1'b0};
               end else if (!new_half && half_mode) begin
                  phase_in = {1'b0, phase_ff[2:1]};
               end
               mode_in = item.step_mode;
            end
         end
         stps_pkg::CMD_LOAD_POS: begin
            position_in = item.position_value;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         reverse_ff    <= 1'b0;
         phase_ff      <= 3'd0;
         steps_left_ff <= 32'd0;
         no_limit_ff   <= 1'b0;
         reload_ff     <= PERIOD_WIDTH'(1);
         countdown_ff  <= '0;
         mode_ff       <= stps_pkg::MODE_HALF;
         position_ff   <= 16'd0;
         total_ff      <= 32'd0;
         coils_ff      <= 4'h0;
      end else if (step_en) begin
         running_ff    <= running_in;
         reverse_ff    <= reverse_in;
         phase_ff      <= phase_in;
         steps_left_ff <= steps_left_in;
         no_limit_ff   <= no_limit_in;
         reload_ff     <= reload_in;
         countdown_ff  <= countdown_in;
         mode_ff       <= mode_in;
         position_ff   <= position_in;
         total_ff      <= total_in;
         coils_ff      <= coils_in;
      end
   end

   always_comb begin
      result.coils       = coils_in;
      result.running     = running_in;
      result.finished    = finished;
      result.accepted    = accepted;
      result.position    = position_in;
      result.step_total  = total_in;
      result.phase_index = phase_in;
   end

   `STPS_ASSERT_IMPLIES(a_idle_coils_off, clock, reset, !running_ff, coils_ff == 4'h0, "coils driven while stopped")
   `STPS_ASSERT_IMPLIES(a_counted_run_left, clock, reset, running_ff && !no_limit_ff, steps_left_ff != 32'd0, "counted run with no steps left")
   `STPS_ASSERT_NEXT(a_stop_halts, clock, reset, step_en && item.command == stps_pkg::CMD_STOP, !running_ff && phase_ff == 3'd0, "stop did not halt the motor")

endmodule
